// ----- rtl/core/gvuf_pkg.sv -----
`timescale 1ns / 1ps

package gvuf_pkg;

  localparam int unsigned MAX_HORIZON_DEF  = 64;
  localparam int unsigned RETURN_WIDTH_DEF = 32;

  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FITTED = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_OMEGA       = 3'd0,
    REG_ALPHA       = 3'd1,
    REG_BETA        = 3'd2,
    REG_MEAN_RETURN = 3'd3,
    REG_FITTED_VAR  = 3'd4,
    REG_MODEL_READY = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQW,
    S_MHI,
    S_MLO,
    S_MADD,
    S_MSAT,
    S_MACC,
    S_ROOT,
    S_RWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] obs_return;
    logic [6:0]         horizon;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] variance;
    logic [31:0] volatility;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] root;
  } sqrt_rsp_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// ----- rtl/core/gvuf_mul.sv -----
`timescale 1ns / 1ps

// 32x32 unsigned multiplier, product registered.
module gvuf_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= {32'd0, a} * {32'd0, b};
  end

endmodule

// ----- rtl/core/gvuf_sqrt.sv -----
`timescale 1ns / 1ps

// Floor square root of a 64-bit value, one result bit per cycle.
module gvuf_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  gvuf_pkg::sqrt_req_t req,
  output gvuf_pkg::sqrt_rsp_t rsp
);

  logic [63:0] val;
  logic [34:0] rem;
  logic [31:0] root;
  logic [4:0]  cnt;
  logic        busy;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        take;

  assign rem_sh = {rem[32:0], val[63:62]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val  <= req.operand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[61:0], 2'b00};
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[30:0], take};
    end
  end

  assign rsp.busy = busy;
  assign rsp.root = root;

endmodule

// ----- rtl/core/garch_variance_update_forecast.sv -----
`timescale 1ns / 1ps

// GARCH(1,1) conditional variance tracker with multi-step forecast.
// Input channel (req_valid/req_stall/req): func 0 updates the variance with a
// new return, func 1 forecasts horizon steps ahead without touching state.
// Output channel (rsp_valid/rsp_stall/rsp): one item per update, one item per
// forecast step (last set on the final one), or one status-only item when the
// model is not fitted (status 1) or the horizon is zero (status 2).
// Config: 64-bit APB-style port, register i at byte address 8*i; writing
// fitted_variance also loads the running variance. Write only while idle.
// Timing: one item at a time; req_stall is high from accept until the
// sequencer is back in idle. A multiply pass (two products on the shared
// 32x32 multiplier, add, carry fix, accumulate) precedes the bit-serial
// square root (launch, then waiting). An update squares the residual and
// runs an alpha pass and a beta pass; each forecast step runs one pass;
// a status-only item goes straight to the output register.
// Reset (rst, synchronous) clears the sequencer, the config registers, rsp_valid and the variance state.
// A stalled output holds its item; the sequencer waits before loading the
// next result, so nothing is lost or repeated.
module garch_variance_update_forecast #(
  parameter int unsigned MAX_HORIZON  = gvuf_pkg::MAX_HORIZON_DEF,
  parameter int unsigned RETURN_WIDTH = gvuf_pkg::RETURN_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                req_valid,
  output logic                                req_stall,
  input  gvuf_pkg::in_item_t                  req,
  // result items
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output gvuf_pkg::out_item_t                 rsp,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gvuf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [gvuf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [gvuf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned CNT_W = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;

  // ---------------- configuration registers ----------------
  logic [63:0]        omega;
  logic [31:0]        alpha;
  logic [31:0]        beta;
  logic signed [31:0] mean_return;
  logic [63:0]        fitted_var;
  logic               model_ready;
  logic [63:0]        cur_var;

  gvuf_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = gvuf_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      gvuf_pkg::REG_OMEGA:       prdata = omega;
      gvuf_pkg::REG_ALPHA:       prdata = {32'd0, alpha};
      gvuf_pkg::REG_BETA:        prdata = {32'd0, beta};
      gvuf_pkg::REG_MEAN_RETURN: prdata = 64'(mean_return);
      gvuf_pkg::REG_FITTED_VAR:  prdata = fitted_var;
      gvuf_pkg::REG_MODEL_READY: prdata = {63'd0, model_ready};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  gvuf_pkg::state_t state, state_next;

  logic                 func_r;
  logic                 pass;        // update: 0 = alpha term, 1 = beta term
  logic                 s_hi;        // forecast factor alpha+beta >= 1.0
  logic [1:0]           status_r;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     n_m1;
  logic [31:0]          mag;
  logic [31:0]          w_reg;
  logic [63:0]          x_reg;
  logic [63:0]          tmp;
  logic [63:0]          acc;

  // multiplier and square root
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          mul_p;
  gvuf_pkg::sqrt_req_t  sq_req;
  gvuf_pkg::sqrt_rsp_t  sq_rsp;

  gvuf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  gvuf_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  // input decode at accept
  logic               accept;
  logic signed [32:0] ret_ext;
  logic signed [32:0] resid;
  logic [32:0]        resid_abs;
  logic [32:0]        ab_sum;
  logic [6:0]         hz_sat;
  logic               out_free;
  logic               emit_last;

  assign req_stall = (state != gvuf_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign ret_ext   = 33'(signed'(req.obs_return[RETURN_WIDTH-1:0]));
  assign resid     = ret_ext - 33'(mean_return);
  assign resid_abs = resid[32] ? 33'(-resid) : 33'(resid);
  assign ab_sum    = {1'b0, alpha} + {1'b0, beta};
  assign hz_sat    = (req.horizon > 7'(MAX_HORIZON)) ? 7'(MAX_HORIZON) : req.horizon;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign emit_last = (status_r != gvuf_pkg::ST_OK) || !func_r || (cnt == n_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gvuf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    mul_a          = w_reg;
    mul_b          = x_reg[63:32];
    sq_req.start   = 1'b0;
    sq_req.operand = acc;
    unique case (state)
      gvuf_pkg::S_IDLE: begin
        if (accept) begin
          if (!model_ready || (req.func && req.horizon == 7'd0)) begin
            state_next = gvuf_pkg::S_EMIT;
          end else if (req.func) begin
            state_next = gvuf_pkg::S_MHI;
          end else begin
            state_next = gvuf_pkg::S_SQ;
          end
        end
      end
      gvuf_pkg::S_SQ: begin
        mul_a      = mag;
        mul_b      = mag;
        state_next = gvuf_pkg::S_SQW;
      end
      gvuf_pkg::S_SQW:  state_next = gvuf_pkg::S_MHI;
      gvuf_pkg::S_MHI:  state_next = gvuf_pkg::S_MLO;
      gvuf_pkg::S_MLO: begin
        mul_b      = x_reg[31:0];
        state_next = gvuf_pkg::S_MADD;
      end
      gvuf_pkg::S_MADD: state_next = gvuf_pkg::S_MSAT;
      gvuf_pkg::S_MSAT: state_next = gvuf_pkg::S_MACC;
      gvuf_pkg::S_MACC: begin
        state_next = (!func_r && !pass) ? gvuf_pkg::S_MHI : gvuf_pkg::S_ROOT;
      end
      gvuf_pkg::S_ROOT: begin
        sq_req.start = 1'b1;
        state_next   = gvuf_pkg::S_RWAIT;
      end
      gvuf_pkg::S_RWAIT: begin
        if (!sq_rsp.busy) begin
          state_next = gvuf_pkg::S_EMIT;
        end
      end
      gvuf_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = emit_last ? gvuf_pkg::S_IDLE : gvuf_pkg::S_MHI;
        end
      end
      default: state_next = gvuf_pkg::S_IDLE;
    endcase
  end

  // config registers and variance state
  always_ff @(posedge clk) begin
    if (rst) begin
      omega       <= '0;
      alpha       <= '0;
      beta        <= '0;
      mean_return <= '0;
      fitted_var  <= '0;
      model_ready <= 1'b0;
      cur_var     <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          gvuf_pkg::REG_OMEGA:       omega       <= pwdata;
          gvuf_pkg::REG_ALPHA:       alpha       <= pwdata[31:0];
          gvuf_pkg::REG_BETA:        beta        <= pwdata[31:0];
          gvuf_pkg::REG_MEAN_RETURN: mean_return <= signed'(pwdata[31:0]);
          gvuf_pkg::REG_FITTED_VAR: begin
            fitted_var <= pwdata;
            cur_var    <= pwdata;
          end
          gvuf_pkg::REG_MODEL_READY: model_ready <= pwdata[0];
          default: ;
        endcase
      end else if (state == gvuf_pkg::S_ROOT && !func_r) begin
        cur_var <= acc;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      gvuf_pkg::S_IDLE: begin
        if (accept) begin
          func_r   <= req.func;
          pass     <= 1'b0;
          cnt      <= '0;
          n_m1     <= CNT_W'(hz_sat - 7'd1);
          mag      <= resid_abs[31:0];
          s_hi     <= ab_sum[32];
          w_reg    <= req.func ? ab_sum[31:0] : alpha;
          x_reg    <= cur_var;
          if (!model_ready) begin
            status_r <= gvuf_pkg::ST_NOT_FITTED;
            acc      <= '0;
          end else if (req.func && req.horizon == 7'd0) begin
            status_r <= gvuf_pkg::ST_EMPTY;
            acc      <= '0;
          end else begin
            status_r <= gvuf_pkg::ST_OK;
            acc      <= omega;
          end
        end
      end
      gvuf_pkg::S_SQW:  x_reg <= mul_p;                        // residual squared
      gvuf_pkg::S_MLO:  tmp   <= mul_p;                        // weight * high word
      gvuf_pkg::S_MADD: tmp   <= tmp + {32'd0, mul_p[63:32]};  // + (weight * low) >> 32
      gvuf_pkg::S_MSAT: begin
        // factor at or above one: add h once more
        if (func_r && s_hi) begin
          tmp <= gvuf_pkg::sat_add64(tmp, x_reg);
        end
      end
      gvuf_pkg::S_MACC: begin
        acc <= gvuf_pkg::sat_add64(acc, tmp);
        if (!func_r && !pass) begin
          pass  <= 1'b1;
          w_reg <= beta;
          x_reg <= cur_var;
        end
      end
      gvuf_pkg::S_EMIT: begin
        if (out_free && !emit_last) begin
          cnt   <= cnt + CNT_W'(1);
          x_reg <= acc;
          acc   <= omega;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == gvuf_pkg::S_EMIT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gvuf_pkg::S_EMIT && out_free) begin
      rsp.status     <= status_r;
      rsp.variance   <= acc;
      rsp.volatility <= (status_r == gvuf_pkg::ST_OK) ? sq_rsp.root : 32'd0;
      rsp.last       <= emit_last;
    end
  end

endmodule

// ----- sim/gvuf_tb_pkg.sv -----
`timescale 1ns / 1ps

package gvuf_tb_pkg;

  // func field of an input item
  localparam logic FUNC_UPDATE   = 1'b0;
  localparam logic FUNC_FORECAST = 1'b1;

endpackage

// ----- sim/gvuf_check.sv -----
`timescale 1ns / 1ps

// Tracks the GARCH(1,1) state from the config bus and the accepted input
// items, and compares every accepted result item against its prediction.
module gvuf_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  gvuf_pkg::in_item_t              req,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  gvuf_pkg::out_item_t             rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gvuf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gvuf_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int unsigned                     errors,
  output int unsigned                     steps_due
);

  logic [63:0]        omega_q;
  logic [31:0]        alpha_q;
  logic [31:0]        beta_q;
  logic signed [31:0] mu;
  logic               ready;
  logic [63:0]        h_now;

  gvuf_pkg::out_item_t variance_steps[$];

  // Q0.32 weight times Q8.56 value, floored back to Q8.56
  function automatic logic [63:0] frac_mul(input logic [31:0] w, input logic [63:0] x);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = {32'b0, w} * {32'b0, x[63:32]};
    lo = {32'b0, w} * {32'b0, x[31:0]};
    return hi + (lo >> 32);
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64]) return '1;
    return s[63:0];
  endfunction

  // bit-by-bit floor square root
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] t;
    logic [63:0] sqr;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      t = root | (32'd1 << b);
      sqr = {32'b0, t} * {32'b0, t};
      if (sqr <= v) root = t;
    end
    return root;
  endfunction

  task automatic push_step(input gvuf_pkg::status_t st, input logic [63:0] v,
                           input logic fin);
    gvuf_pkg::out_item_t r;
    r.status     = st;
    r.variance   = v;
    r.volatility = (st == gvuf_pkg::ST_OK) ? floor_sqrt(v) : 32'd0;
    r.last       = fin;
    variance_steps.insert(variance_steps.size(), r);
  endtask

  task automatic garch_step(input gvuf_pkg::in_item_t it);
    logic signed [33:0] r_ext;
    logic signed [33:0] m_ext;
    logic signed [33:0] resid;
    logic [63:0]        mag;
    logic [63:0]        v;
    logic [63:0]        p;
    logic [32:0]        ab;
    int unsigned        n;
    if (!ready) begin
      push_step(gvuf_pkg::ST_NOT_FITTED, '0, 1'b1);
      return;
    end
    if (it.func == gvuf_tb_pkg::FUNC_UPDATE) begin
      r_ext = 34'(signed'(it.obs_return));
      m_ext = 34'(mu);
      resid = r_ext - m_ext;
      mag   = resid[33] ? 64'(-resid) : 64'(resid);
      v     = add_sat(omega_q, frac_mul(alpha_q, mag * mag));
      v     = add_sat(v, frac_mul(beta_q, h_now));
      h_now = v;
      push_step(gvuf_pkg::ST_OK, v, 1'b1);
      return;
    end
    n = {25'd0, it.horizon};
    if (n == 0) begin
      push_step(gvuf_pkg::ST_EMPTY, '0, 1'b1);
      return;
    end
    if (n > gvuf_pkg::MAX_HORIZON_DEF) n = gvuf_pkg::MAX_HORIZON_DEF;
    ab = {1'b0, alpha_q} + {1'b0, beta_q};
    v  = h_now;
    for (int i = 0; i < n; i++) begin
      p = frac_mul(ab[31:0], v);
      if (ab[32]) p = add_sat(p, v);
      v = add_sat(omega_q, p);
      push_step(gvuf_pkg::ST_OK, v, i == n - 1);
    end
  endtask

  always @(posedge clk) begin
    gvuf_pkg::out_item_t want;
    if (rst) begin
      omega_q = '0;
      alpha_q = '0;
      beta_q  = '0;
      mu      = '0;
      ready   = 1'b0;
      h_now   = '0;
      variance_steps.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (variance_steps.size() == 0) begin
          $error("unexpected result item: variance %h", rsp.variance);
          errors++;
        end else begin
          want = variance_steps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.variance !== want.variance) begin
            $error("variance mismatch: expected %h, got %h", want.variance, rsp.variance);
            errors++;
          end
          if (rsp.volatility !== want.volatility) begin
            $error("volatility mismatch: expected %h, got %h",
                   want.volatility, rsp.volatility);
            errors++;
          end
          if (rsp.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, rsp.last);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) garch_step(req);
      if (psel && penable && pwrite && pready) begin
        case (gvuf_pkg::reg_idx_t'(paddr[gvuf_pkg::CFG_ADDR_W-1:3]))
          gvuf_pkg::REG_OMEGA:       omega_q = pwdata;
          gvuf_pkg::REG_ALPHA:       alpha_q = pwdata[31:0];
          gvuf_pkg::REG_BETA:        beta_q  = pwdata[31:0];
          gvuf_pkg::REG_MEAN_RETURN: mu      = pwdata[31:0];
          gvuf_pkg::REG_FITTED_VAR:  h_now   = pwdata;
          gvuf_pkg::REG_MODEL_READY: ready   = pwdata[0];
          default: ;
        endcase
      end
    end
    steps_due = variance_steps.size();
  end

endmodule

// ----- sim/garch_variance_update_forecast_tb.sv -----
`timescale 1ns / 1ps

// Drives input items and config writes into the GARCH block; the checker
// beside it predicts and compares, this module only makes stimulus and
// gives the verdict.
module garch_variance_update_forecast_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no item moving
  localparam int unsigned HOLD_CYCLES    = 300;   // long output back-pressure
  localparam int unsigned DRAIN_CYCLES   = 100;   // idle wait after the final drain
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 50;

  localparam logic [2:0]         REG_PAST_END = 3'd7;  // no register here
  localparam logic signed [31:0] RET_MAX      = 32'sh7fff_ffff;
  localparam logic signed [31:0] RET_MIN      = 32'sh8000_0000;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  gvuf_pkg::in_item_t              req       = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  gvuf_pkg::out_item_t             rsp;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [gvuf_pkg::CFG_ADDR_W-1:0] paddr     = '0;
  logic [gvuf_pkg::CFG_DATA_W-1:0] pwdata    = '0;
  logic [gvuf_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int unsigned errors;
  int unsigned steps_due;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned idle_cycles   = 0;
  logic        hold_req      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  garch_variance_update_forecast u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  gvuf_check u_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .errors    (errors),
    .steps_due (steps_due)
  );

  // Result side. Normally random stalls at stall_pct; the first time hold_req
  // is seen it holds off for HOLD_CYCLES straight so the output register and
  // then the input channel back up while the sender keeps offering.
  initial begin
    logic held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          rsp_stall <= 1'b1;
        end
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: any item moving on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One item: random idle gaps first, then hold the payload until accepted.
  // Valid stays high on return; the next call or drain decides at the next
  // falling edge, so valid gets one assignment per step.
  task automatic send_item(input gvuf_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do begin
      @(posedge clk);
    end while (req_stall);
  endtask

  // horizon is don't-care for an update, so it gets random bits
  task automatic update(input logic signed [31:0] ret);
    gvuf_pkg::in_item_t it;
    it.func       = gvuf_tb_pkg::FUNC_UPDATE;
    it.obs_return = ret;
    it.horizon    = 7'($urandom_range(127));
    send_item(it);
  endtask

  task automatic forecast(input logic [6:0] n);
    gvuf_pkg::in_item_t it;
    it.func       = gvuf_tb_pkg::FUNC_FORECAST;
    it.obs_return = $urandom();
    it.horizon    = n;
    send_item(it);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    wait (steps_due == 0);
  endtask

  // setup cycle, access cycle, done at the edge with pready high
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Whole model load; fitted variance also sets the running variance.
  task automatic load_model(input logic [63:0] om, input logic [31:0] al,
                            input logic [31:0] be, input logic signed [31:0] mr,
                            input logic [63:0] fv, input logic rdy);
    drain();
    cfg_write(gvuf_pkg::REG_OMEGA, om);
    cfg_write(gvuf_pkg::REG_ALPHA, {32'b0, al});
    cfg_write(gvuf_pkg::REG_BETA, {32'b0, be});
    cfg_write(gvuf_pkg::REG_MEAN_RETURN, {{32{mr[31]}}, mr});
    cfg_write(gvuf_pkg::REG_FITTED_VAR, fv);
    cfg_write(gvuf_pkg::REG_MODEL_READY, {63'b0, rdy});
  endtask

  // wide Q8.56 value spread over many magnitudes
  function automatic logic [63:0] rand_wide();
    return {$urandom(), $urandom()} >> $urandom_range(63);
  endfunction

  function automatic logic [31:0] rand_weight();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  initial begin
    logic signed [31:0] ret;
    int unsigned        pick;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // --- directed ---------------------------------------------------------
    // Nothing loaded yet: every item, empty horizon included, is not-fitted.
    update(32'sd0);
    forecast(7'd3);
    forecast(7'd0);

    // Typical fit: omega ~1e-6, alpha ~0.1, beta ~0.85, small mean.
    load_model(64'h0000_0010_c6f7_a0b5, 32'h1999_999a, 32'hd999_999a,
               32'sd134218, 64'h0001_a36e_2eb1_c432, 1'b1);
    update(32'sd0);
    update(RET_MAX);
    update(RET_MIN);
    update(-32'sd1);
    update(32'sd1);
    forecast(7'd0);    // empty request
    forecast(7'd1);
    forecast(7'd64);
    forecast(7'd65);   // clipped to max horizon
    forecast(7'd127);

    // Everything at full scale: sums saturate, alpha+beta carries past 1.0.
    load_model('1, '1, '1, RET_MAX, '1, 1'b1);
    update(RET_MIN);
    forecast(7'd4);

    // All weights zero, mean at the negative extreme.
    load_model('0, '0, '0, RET_MIN, '0, 1'b1);
    update(RET_MAX);
    forecast(7'd2);

    // Write past the register list must change nothing.
    drain();
    cfg_write(REG_PAST_END, '1);
    forecast(7'd2);

    // Drop ready, then bring it back with a fresh running variance.
    drain();
    cfg_write(gvuf_pkg::REG_MODEL_READY, '0);
    update(32'sd5);
    drain();
    cfg_write(gvuf_pkg::REG_MODEL_READY, 64'd1);
    cfg_write(gvuf_pkg::REG_FITTED_VAR, 64'h0100_0000_0000_0000);
    forecast(7'd1);

    // --- random -----------------------------------------------------------
    // Each phase picks an idling pattern and a fresh model, then mostly
    // short forecasts and updates with a few long horizons.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 64;
        end
        default: begin
          send_idle_pct = 20;
          stall_pct     = 20;
        end
      endcase
      ret = $urandom();
      load_model(rand_wide(), rand_weight(), rand_weight(),
                 ret >>> $urandom_range(31), rand_wide(), $urandom_range(9) != 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long hold-off while the sender keeps going
        if (ph == 0 && k == PHASE_ITEMS / 2) hold_req = 1'b1;
        pick = $urandom_range(99);
        if ($urandom_range(1) == 0) begin
          ret = $urandom();
          if (pick < 5) ret = RET_MAX;
          else if (pick < 10) ret = RET_MIN;
          else ret = ret >>> $urandom_range(31);
          update(ret);
        end else if (pick < 6) begin
          forecast(7'd0);
        end else if (pick < 10) begin
          forecast(7'($urandom_range(127, 60)));
        end else begin
          forecast(7'($urandom_range(8, 1)));
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/gvuf_pkg.sv
rtl/core/gvuf_mul.sv
rtl/core/gvuf_sqrt.sv
rtl/core/garch_variance_update_forecast.sv
sim/gvuf_tb_pkg.sv
sim/gvuf_check.sv
sim/garch_variance_update_forecast_tb.sv
